### rtl/bba_pkg.sv
// Shared types and constants for the buddy block allocator.
// No dependencies.
package bba_pkg;

  localparam int unsigned PoolWords = 128;
  localparam int unsigned OffW      = $clog2(PoolWords);
  localparam int unsigned TopClass  = OffW;
  localparam int unsigned ClassW    = 3;

  typedef enum logic [0:0] {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ALLOC_ERR = 2'd1,
    ST_BAD_REL   = 2'd2
  } status_t;

  typedef struct packed {
    logic        command;
    logic [15:0] request_bytes;
    logic [15:0] release_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_addr;
  } out_item_t;

  // One word of block state: start flag, used flag, class.
  typedef struct packed {
    logic              start;
    logic              used;
    logic [ClassW-1:0] cls;
  } blk_t;

endpackage

### rtl/bba_state_ram.sv
// Single-port-write, single-read block state memory with registered read.
// Depends on bba_pkg.
module bba_state_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [bba_pkg::OffW-1:0]   waddr,
  input  bba_pkg::blk_t              wdata,
  input  logic [bba_pkg::OffW-1:0]   raddr,
  output bba_pkg::blk_t              rdata
);

  bba_pkg::blk_t mem [bba_pkg::PoolWords];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/buddy_block_allocator_core.sv
// Buddy block allocator core: top level.
// Depends on bba_pkg and bba_state_ram.
//
// Use: pulse start with in_item while busy is low. busy rises the next
// cycle and stays high until the result is shown. The result appears on
// out_item for one cycle with out_valid high; it cannot be held off.
// cfg_we / cfg_wdata write header_bytes (reset 32); the user must do so
// only while the block is idle, as the block itself does not enforce it.
//
// Block state lives in one 128-entry memory with registered read. After
// reset a clearing pass writes every word (busy high), putting the whole
// pool in one free block at word 0. Allocate: a scan reads every word once
// to find the smallest lowest free block, then one write per split step
// and one to mark it. Release: read and check the block, then per merge
// step one buddy read and two writes (up to 7 steps). One transaction at a
// time: a new request is taken only while busy is low.
module buddy_block_allocator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  bba_pkg::in_item_t   in_item,
  output logic                busy,
  output logic                out_valid,
  output bba_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata
);

  localparam int unsigned OW = bba_pkg::OffW;
  localparam int unsigned CW = bba_pkg::ClassW;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_SCAN   = 10'b0000000100,
    S_SPLIT  = 10'b0000001000,
    S_RCHK   = 10'b0000010000,
    S_RWAIT  = 10'b0000100000,
    S_MREQ   = 10'b0001000000,
    S_MCHK   = 10'b0010000000,
    S_MHI    = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]    hdr_r;
  logic [OW:0]   cnt_r, cnt_nxt;      // scan / clear counter, one bit wider for end
  logic [OW-1:0] off_r, off_nxt;      // working offset
  logic [CW-1:0] cls_r, cls_nxt;      // working class
  logic [CW-1:0] need_r, need_nxt;
  logic          found_r, found_nxt;
  logic [OW-1:0] prev_r;              // offset of word being returned by memory
  logic          pvld_r;
  logic [1:0]    stat_r, stat_nxt;
  logic [15:0]   addr_r, addr_nxt;
  logic          ov_r;

  logic          we;
  logic [OW-1:0] waddr, raddr;
  bba_pkg::blk_t wdata, rdata;

  bba_state_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Class needed for an allocate
  logic [17:0] words_w;
  logic [CW:0] need_w;
  always_comb begin
    words_w = (18'(in_item.request_bytes) + 18'(hdr_r) + 18'd3) >> 2;
    need_w  = '0;
    for (int i = 0; i < 17; i++) begin
      if ((18'd1 << i) < words_w) begin
        need_w = (CW+1)'(i + 1);
      end
    end
  end

  // Release address decode
  logic [15:0] rel_sub;
  logic        rel_ok;
  always_comb begin
    rel_sub = in_item.release_addr - 16'(hdr_r);
    rel_ok  = (in_item.release_addr >= 16'(hdr_r)) && (rel_sub[1:0] == 2'b00)
              && (rel_sub[15:2] < 14'(bba_pkg::PoolWords));
  end

  logic [OW-1:0] bud;
  assign bud = off_r ^ OW'(1 << cls_r);

  // Control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    off_nxt   = off_r;
    cls_nxt   = cls_r;
    need_nxt  = need_r;
    found_nxt = found_r;
    stat_nxt  = stat_r;
    addr_nxt  = addr_r;
    we        = 1'b0;
    waddr     = off_r;
    wdata     = '0;
    raddr     = cnt_r[OW-1:0];
    case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_r[OW-1:0];
        if (cnt_r[OW-1:0] == '0) begin
          wdata = '{start: 1'b1, used: 1'b0, cls: CW'(bba_pkg::TopClass)};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[OW-1:0] == OW'(bba_pkg::PoolWords - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt   = '0;
        found_nxt = 1'b0;
        addr_nxt  = '0;
        if (start) begin
          if (in_item.command == bba_pkg::CMD_ALLOC) begin
            need_nxt = need_w[CW-1:0];
            if (in_item.request_bytes == '0 || need_w > (CW+1)'(bba_pkg::TopClass)) begin
              stat_nxt  = bba_pkg::ST_ALLOC_ERR;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (!rel_ok) begin
            stat_nxt  = bba_pkg::ST_BAD_REL;
            state_nxt = S_DONE;
          end else begin
            off_nxt   = rel_sub[OW+1:2];
            state_nxt = S_RWAIT;
          end
        end
      end
      S_SCAN: begin
        // Issue reads for every word; examine the word read last cycle
        raddr = cnt_r[OW-1:0];
        if (!cnt_r[OW]) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (pvld_r && rdata.start && !rdata.used && rdata.cls >= need_r &&
            (!found_r || rdata.cls < cls_r)) begin
          found_nxt = 1'b1;
          off_nxt   = prev_r;
          cls_nxt   = rdata.cls;
        end
        if (!pvld_r && cnt_r[OW]) begin
          if (found_r) begin
            state_nxt = S_SPLIT;
          end else begin
            stat_nxt  = bba_pkg::ST_ALLOC_ERR;
            state_nxt = S_DONE;
          end
        end
      end
      S_SPLIT: begin
        // One upper half per cycle, then mark the block used
        we = 1'b1;
        if (cls_r > need_r) begin
          waddr   = off_r + OW'(1 << (cls_r - 1'b1));
          wdata   = '{start: 1'b1, used: 1'b0, cls: cls_r - 1'b1};
          cls_nxt = cls_r - 1'b1;
        end else begin
          waddr     = off_r;
          wdata     = '{start: 1'b1, used: 1'b1, cls: cls_r};
          stat_nxt  = bba_pkg::ST_OK;
          addr_nxt  = 16'({off_r, 2'b00}) + 16'(hdr_r);
          state_nxt = S_DONE;
        end
      end
      S_RWAIT: begin
        raddr     = off_r;
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        if (!rdata.start || !rdata.used) begin
          stat_nxt  = bba_pkg::ST_BAD_REL;
          state_nxt = S_DONE;
        end else begin
          we        = 1'b1;
          waddr     = off_r;
          wdata     = '{start: 1'b1, used: 1'b0, cls: rdata.cls};
          cls_nxt   = rdata.cls;
          stat_nxt  = bba_pkg::ST_OK;
          state_nxt = S_MREQ;
        end
      end
      S_MREQ: begin
        raddr = bud;
        if (cls_r >= CW'(bba_pkg::TopClass)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (!rdata.start || rdata.used || rdata.cls != cls_r) begin
          state_nxt = S_DONE;
        end else begin
          // Clear the upper of the pair
          we        = 1'b1;
          waddr     = (off_r < bud) ? bud : off_r;
          wdata     = '0;
          off_nxt   = (off_r < bud) ? off_r : bud;
          state_nxt = S_MHI;
        end
      end
      S_MHI: begin
        // Write the merged block at the lower offset
        we        = 1'b1;
        waddr     = off_r;
        wdata     = '{start: 1'b1, used: 1'b0, cls: cls_r + 1'b1};
        cls_nxt   = cls_r + 1'b1;
        state_nxt = S_MREQ;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      hdr_r   <= 7'd32;
      pvld_r  <= 1'b0;
      ov_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      pvld_r  <= (state_r == S_SCAN) && !cnt_r[OW];
      ov_r    <= (state_r == S_DONE);
      if (cfg_we) begin
        hdr_r <= cfg_wdata;
      end
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    cls_r  <= cls_nxt;
    need_r <= need_nxt;
    stat_r <= stat_nxt;
    addr_r <= (stat_nxt == bba_pkg::ST_OK) ? addr_nxt : 16'd0;
    prev_r <= cnt_r[OW-1:0];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = '{status: stat_r, granted_addr: addr_r};

endmodule
